@@ rtl/core/mbps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mbps_pkg;

  // longest pattern the scanner can ever compare
  localparam int unsigned MaxPattern = 16;
  localparam int unsigned LenW       = 5;
  localparam int unsigned AddrW      = 32;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatternLow  = 3'd0,
    CfgPatternHigh = 3'd1,
    CfgCareMask    = 3'd2,
    CfgPatternLen  = 3'd3,
    CfgScanLen     = 3'd4,
    CfgBaseAddr    = 3'd5
  } cfg_reg_e;

  // shared control for every cell of the chain
  typedef struct packed {
    logic            step;
    logic            flush;
    logic [LenW-1:0] len;
  } cell_ctrl_t;

  typedef struct packed {
    logic             found;
    logic [AddrW-1:0] addr;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/mbps_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mbps_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire  mbps_pkg::cell_ctrl_t   ctrl_i,
  input  wire                          live_i,
  input  wire  [7:0]                   byte_i,
  input  wire  [7:0]                   pattern_byte_i,
  input  wire                          care_i,
  output logic                         match_o,
  output logic                         pass_o
);

  // pattern position handled here, counted from one
  localparam logic [mbps_pkg::LenW-1:0] Pos1 = mbps_pkg::LenW'(CellIdx + 1);

  logic hit;
  logic pass_d;
  logic pass_q;

  assign hit     = !care_i || (pattern_byte_i == byte_i);
  assign match_o = live_i && hit && (Pos1 == ctrl_i.len);
  assign pass_d  = live_i && hit && (Pos1 < ctrl_i.len) && !ctrl_i.flush;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q <= 1'b0;
    end else if (ctrl_i.step) begin
      pass_q <= pass_d;
    end
  end

  assign pass_o = pass_q;

endmodule

`default_nettype wire

@@ rtl/core/mbps_out_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mbps_out_reg (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    load_i,
  input  wire mbps_pkg::result_t result_i,
  output logic                   space_o,
  output logic                   valid_o,
  input  wire                    ready_i,
  output mbps_pkg::result_t      result_o
);

  logic              valid_d;
  logic              valid_q;
  mbps_pkg::result_t result_q;

  assign space_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

@@ rtl/core/masked_byte_pattern_scanner_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Scans a byte stream for the first start offset below scan_length where a
// masked pattern of up to 16 bytes matches, and reports base_address plus that
// offset (or found=0 with address 0 when the region ends without a match).
// One byte is taken every cycle; a chain of compare cells, one per pattern
// position, carries each open start forward by one position per byte. The
// result is registered and shows up on the output the cycle after the byte
// that decides it; input stalls only while that register holds an untaken
// result and the output side is not ready. After last_byte the scan restarts
// at offset 0 with the next byte. Configuration writes take effect on the
// next byte.
module masked_byte_pattern_scanner_core #(
  parameter int unsigned PatternBytes = 16
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire  [mbps_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire  [mbps_pkg::CfgDataW-1:0]     cfg_data_i,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire  [7:0]                        byte_value_i,
  input  wire                               last_byte_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic                              found_o,
  output logic [mbps_pkg::AddrW-1:0]        match_address_o
);

  localparam int unsigned NumCells = (PatternBytes < mbps_pkg::MaxPattern) ?
                                     PatternBytes : mbps_pkg::MaxPattern;
  localparam logic [mbps_pkg::LenW-1:0] LenCap = mbps_pkg::LenW'(NumCells);

  // configuration
  logic [63:0]                   pat_low_q;
  logic [63:0]                   pat_high_q;
  logic [15:0]                   care_q;
  logic [mbps_pkg::LenW-1:0]     pat_len_q;
  logic [mbps_pkg::AddrW-1:0]    scan_len_q;
  logic [mbps_pkg::AddrW-1:0]    base_q;

  // scan state
  logic [mbps_pkg::AddrW-1:0]    offset_q;
  logic [mbps_pkg::AddrW-1:0]    offset_d;
  logic                          finished_q;
  logic                          finished_d;
  logic                          wrapped_q;
  logic                          wrapped_d;

  logic [127:0]                  pat_all;
  logic [mbps_pkg::LenW-1:0]     len_used;
  logic [mbps_pkg::LenW-1:0]     back_off;
  logic                          len_zero;
  logic                          xfer_in;
  logic                          start_en;
  logic                          matched;
  logic                          emit;
  logic                          space;
  logic [mbps_pkg::AddrW-1:0]    hit_addr;
  logic [NumCells:0]             live;
  logic [NumCells-1:0]           cell_match;
  mbps_pkg::cell_ctrl_t          ctrl;
  mbps_pkg::result_t             res_in;
  mbps_pkg::result_t             res_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      care_q     <= 16'hFFFF;
      pat_len_q  <= '0;
      scan_len_q <= '0;
      base_q     <= '0;
    end else if (cfg_we_i) begin
      case (mbps_pkg::cfg_reg_e'(cfg_index_i))
        mbps_pkg::CfgPatternLow:  pat_low_q  <= cfg_data_i;
        mbps_pkg::CfgPatternHigh: pat_high_q <= cfg_data_i;
        mbps_pkg::CfgCareMask:    care_q     <= cfg_data_i[15:0];
        mbps_pkg::CfgPatternLen:  pat_len_q  <= cfg_data_i[mbps_pkg::LenW-1:0];
        mbps_pkg::CfgScanLen:     scan_len_q <= cfg_data_i[mbps_pkg::AddrW-1:0];
        mbps_pkg::CfgBaseAddr:    base_q     <= cfg_data_i[mbps_pkg::AddrW-1:0];
        default: ;
      endcase
    end
  end

  assign pat_all  = {pat_high_q, pat_low_q};
  assign len_used = (pat_len_q > LenCap) ? LenCap : pat_len_q;
  assign len_zero = (len_used == '0);
  assign back_off = len_zero ? '0 : (len_used - mbps_pkg::LenW'(1));

  assign xfer_in  = in_valid_i && in_ready_o;
  assign start_en = !finished_q && !wrapped_q && (offset_q < scan_len_q);

  assign ctrl.step  = xfer_in;
  assign ctrl.flush = last_byte_i || matched || finished_q;
  assign ctrl.len   = len_used;

  // a new start enters the chain at position zero
  assign live[0] = start_en;

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    mbps_cell #(
      .CellIdx(k)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (ctrl),
      .live_i         (live[k]),
      .byte_i         (byte_value_i),
      .pattern_byte_i (pat_all[8*k +: 8]),
      .care_i         (care_q[k]),
      .match_o        (cell_match[k]),
      .pass_o         (live[k+1])
    );
  end

  assign matched  = !finished_q && ((|cell_match) || (start_en && len_zero));
  assign emit     = !finished_q && (matched || last_byte_i);
  // start of the completed window is the current offset minus its progress
  assign hit_addr = base_q + offset_q - mbps_pkg::AddrW'(back_off);

  assign res_in.found = matched;
  assign res_in.addr  = matched ? hit_addr : '0;

  always_comb begin
    offset_d   = offset_q;
    finished_d = finished_q;
    wrapped_d  = wrapped_q;
    if (last_byte_i) begin
      offset_d   = '0;
      finished_d = 1'b0;
      wrapped_d  = 1'b0;
    end else if (!finished_q) begin
      offset_d   = offset_q + mbps_pkg::AddrW'(1);
      finished_d = matched;
      if (offset_q == '1) begin
        wrapped_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q   <= '0;
      finished_q <= 1'b0;
      wrapped_q  <= 1'b0;
    end else if (xfer_in) begin
      offset_q   <= offset_d;
      finished_q <= finished_d;
      wrapped_q  <= wrapped_d;
    end
  end

  mbps_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (xfer_in && emit),
    .result_i (res_in),
    .space_o  (space),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .result_o (res_out)
  );

  assign in_ready_o      = space;
  assign found_o         = res_out.found;
  assign match_address_o = res_out.addr;

  // the last position can only complete a match, never hand on
  a_last_cell_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !live[NumCells])
    else $error("last cell passed a live start");

  // only one open start can complete on a given byte
  a_single_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cell_match))
    else $error("more than one cell matched");

  // once a match is reported the chain holds no open starts
  a_chain_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |-> (live[NumCells:1] == '0))
    else $error("open starts remain after a match");

  // a match transfer always ends the scan
  a_match_finishes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer_in && matched && !last_byte_i) |=> finished_q)
    else $error("scan not finished after a match");

endmodule

`default_nettype wire
